>>> sv/saes_pkg.sv
package saes_pkg;

  localparam int unsigned BLOCK_W = 16;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned NIB_W   = 4;

  localparam logic [BYTE_W-1:0] RCON1 = 8'b1000_0000;
  localparam logic [BYTE_W-1:0] RCON2 = 8'b0011_0000;

  // GF(16) column mix coefficients
  localparam logic [NIB_W-1:0] MIX_FWD_D = 4'h1;
  localparam logic [NIB_W-1:0] MIX_FWD_O = 4'h4;
  localparam logic [NIB_W-1:0] MIX_INV_D = 4'h9;
  localparam logic [NIB_W-1:0] MIX_INV_O = 4'h2;

  localparam logic [NIB_W-1:0] FWD_SBOX [16] = '{
    4'h9, 4'h4, 4'hA, 4'hB, 4'hD, 4'h1, 4'h8, 4'h5,
    4'h6, 4'h2, 4'h0, 4'h3, 4'hC, 4'hE, 4'hF, 4'h7
  };

  localparam logic [NIB_W-1:0] INV_SBOX [16] = '{
    4'hA, 4'h5, 4'h9, 4'hB, 4'h1, 4'h7, 4'h8, 4'hF,
    4'h6, 4'h0, 4'h2, 4'h3, 4'hC, 4'h4, 4'hD, 4'hE
  };

  typedef struct packed {
    logic [BLOCK_W-1:0] k0;
    logic [BLOCK_W-1:0] k1;
    logic [BLOCK_W-1:0] k2;
  } round_keys_t;

  // multiply modulo x^4 + x + 1
  function automatic logic [NIB_W-1:0] gf_mul(logic [NIB_W-1:0] a, logic [NIB_W-1:0] b);
    logic [NIB_W-1:0] acc;
    logic [NIB_W-1:0] aa;
    logic             carry;
    acc = '0;
    aa  = a;
    for (int i = 0; i < NIB_W; i++) begin
      if (b[i]) begin
        acc = acc ^ aa;
      end
      carry = aa[NIB_W-1];
      aa    = {aa[NIB_W-2:0], 1'b0};
      if (carry) begin
        aa = aa ^ 4'h3;
      end
    end
    return acc;
  endfunction

  function automatic logic [NIB_W-1:0] sbox(logic [NIB_W-1:0] n, logic inv);
    return inv ? INV_SBOX[n] : FWD_SBOX[n];
  endfunction

  // substitute nibbles, then swap nibbles 1 and 3
  function automatic logic [BLOCK_W-1:0] sub_shift(logic [BLOCK_W-1:0] v, logic inv);
    return {sbox(v[15:12], inv), sbox(v[3:0], inv), sbox(v[7:4], inv), sbox(v[11:8], inv)};
  endfunction

  function automatic logic [BLOCK_W-1:0] mix(logic [BLOCK_W-1:0] v, logic [NIB_W-1:0] d,
                                             logic [NIB_W-1:0] o);
    logic [NIB_W-1:0] a;
    logic [NIB_W-1:0] b;
    logic [NIB_W-1:0] c;
    logic [NIB_W-1:0] e;
    a = v[15:12];
    b = v[11:8];
    c = v[7:4];
    e = v[3:0];
    return {gf_mul(d, a) ^ gf_mul(o, b), gf_mul(o, a) ^ gf_mul(d, b),
            gf_mul(d, c) ^ gf_mul(o, e), gf_mul(o, c) ^ gf_mul(d, e)};
  endfunction

  function automatic logic [BYTE_W-1:0] rot_sub(logic [BYTE_W-1:0] w);
    return {FWD_SBOX[w[3:0]], FWD_SBOX[w[7:4]]};
  endfunction

  function automatic round_keys_t expand_key(logic [BLOCK_W-1:0] key);
    logic [BYTE_W-1:0] w0;
    logic [BYTE_W-1:0] w1;
    logic [BYTE_W-1:0] w2;
    logic [BYTE_W-1:0] w3;
    logic [BYTE_W-1:0] w4;
    logic [BYTE_W-1:0] w5;
    round_keys_t       rk;
    w0 = key[15:8];
    w1 = key[7:0];
    w2 = w0 ^ RCON1 ^ rot_sub(w1);
    w3 = w2 ^ w1;
    w4 = w2 ^ RCON2 ^ rot_sub(w3);
    w5 = w4 ^ w3;
    rk.k0 = {w0, w1};
    rk.k1 = {w2, w3};
    rk.k2 = {w4, w5};
    return rk;
  endfunction

  function automatic logic [BLOCK_W-1:0] encrypt(logic [BLOCK_W-1:0] v, round_keys_t rk);
    logic [BLOCK_W-1:0] t;
    t = v ^ rk.k0;
    t = sub_shift(t, 1'b0);
    t = mix(t, MIX_FWD_D, MIX_FWD_O) ^ rk.k1;
    t = sub_shift(t, 1'b0);
    return t ^ rk.k2;
  endfunction

  function automatic logic [BLOCK_W-1:0] decrypt(logic [BLOCK_W-1:0] v, round_keys_t rk);
    logic [BLOCK_W-1:0] t;
    t = v ^ rk.k2;
    t = sub_shift(t, 1'b1) ^ rk.k1;
    t = mix(t, MIX_INV_D, MIX_INV_O);
    t = sub_shift(t, 1'b1);
    return t ^ rk.k0;
  endfunction

endpackage

>>> sv/simplified_aes_cipher.sv
// The input register captures each input transaction, and the result register its result.
// Throughput: one transaction per cycle unless held by out_stall; the cipher rounds are one
// combinational pass between the two registers, round keys are expanded once per key write.
// Reset (rst_n low, synchronous): both stages empty, key cleared to zero and
// round keys set to the expansion of the zero key.
module simplified_aes_cipher (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_operation,
  input  logic [saes_pkg::BLOCK_W-1:0]   in_data_block,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [saes_pkg::BLOCK_W-1:0]   out_result_block,
  input  logic                           cfg_wr_en,
  input  logic [saes_pkg::BLOCK_W-1:0]   cfg_wr_data
);
  import saes_pkg::*;

  round_keys_t        rk_r;
  round_keys_t        rk_nxt;
  logic               s1_valid_r;
  logic               s1_op_r;
  logic [BLOCK_W-1:0] s1_data_r;
  logic               out_valid_r;
  logic [BLOCK_W-1:0] out_data_r;
  logic [BLOCK_W-1:0] out_data_nxt;
  logic               out_ready;
  logic               in_ready;

  assign out_ready = !out_valid_r || !out_stall;
  assign in_ready  = !s1_valid_r || out_ready;
  assign in_stall  = !in_ready;

  assign rk_nxt       = expand_key(cfg_wr_data);
  assign out_data_nxt = s1_op_r ? decrypt(s1_data_r, rk_r) : encrypt(s1_data_r, rk_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rk_r <= expand_key('0);
    end else if (cfg_wr_en) begin
      rk_r <= rk_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_op_r   <= in_operation;
      s1_data_r <= in_data_block;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && s1_valid_r) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_block = out_data_r;

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("input stalled without a blocked result");

  a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_ready) |=> out_valid_r)
    else $error("staged transaction lost");

  a_key_expand: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr_en |=> (rk_r == expand_key($past(cfg_wr_data))))
    else $error("round keys do not match written key");

  a_key_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (!cfg_wr_en && $past(rst_n)) |=> $stable(rk_r))
    else $error("round keys changed without a write");

endmodule

>>> tb/sv/saes_tb_pkg.sv
package saes_tb_pkg;

  typedef enum logic {
    OP_ENCRYPT = 1'b0,
    OP_DECRYPT = 1'b1
  } cipher_op_e;

  localparam int unsigned PIPE_LATENCY = 2;

endpackage

>>> tb/sv/saes_cipher_checker.sv
module saes_cipher_checker
  import saes_tb_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic                         in_operation,
  input  logic [saes_pkg::BLOCK_W-1:0] in_data_block,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic [saes_pkg::BLOCK_W-1:0] out_result_block,
  input  logic                         cfg_wr_en,
  input  logic [saes_pkg::BLOCK_W-1:0] cfg_wr_data,
  output int                           mismatch_count,
  output int                           pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [3:0]  nibble_t;
  typedef logic [7:0]  key_byte_t;
  typedef logic [15:0] block_t;

  typedef struct packed {
    block_t k0;
    block_t k1;
    block_t k2;
  } key_schedule_t;

  localparam key_byte_t ROUND_CONST_1 = 8'h80;
  localparam key_byte_t ROUND_CONST_2 = 8'h30;
  localparam nibble_t   ENC_DIAG      = 4'h1;
  localparam nibble_t   ENC_OFF       = 4'h4;
  localparam nibble_t   DEC_DIAG      = 4'h9;
  localparam nibble_t   DEC_OFF       = 4'h2;

  localparam nibble_t ENC_SUBST [16] = '{
    4'h9, 4'h4, 4'hA, 4'hB, 4'hD, 4'h1, 4'h8, 4'h5,
    4'h6, 4'h2, 4'h0, 4'h3, 4'hC, 4'hE, 4'hF, 4'h7
  };
  localparam nibble_t DEC_SUBST [16] = '{
    4'hA, 4'h5, 4'h9, 4'hB, 4'h1, 4'h7, 4'h8, 4'hF,
    4'h6, 4'h0, 4'h2, 4'h3, 4'hC, 4'h4, 4'hD, 4'hE
  };

  block_t key_copy;
  block_t expected_blocks [$];

  // GF(16), reduction by x^4 + x + 1
  function automatic nibble_t gf16_times(nibble_t x, nibble_t y);
    nibble_t prod;
    nibble_t sh;
    prod = '0;
    sh   = x;
    for (int k = 0; k < 4; k++) begin
      if (y[k]) begin
        prod = prod ^ sh;
      end
      sh = sh[3] ? ({sh[2:0], 1'b0} ^ 4'h3) : {sh[2:0], 1'b0};
    end
    return prod;
  endfunction

  function automatic nibble_t subst(nibble_t n, cipher_op_e dir);
    return (dir == OP_DECRYPT) ? DEC_SUBST[n] : ENC_SUBST[n];
  endfunction

  // substitution, then swap of nibbles 1 and 3
  function automatic block_t subst_swap(block_t v, cipher_op_e dir);
    return {subst(v[15:12], dir), subst(v[3:0], dir), subst(v[7:4], dir),
            subst(v[11:8], dir)};
  endfunction

  function automatic block_t column_mix(block_t v, nibble_t diag, nibble_t off);
    return {gf16_times(diag, v[15:12]) ^ gf16_times(off, v[11:8]),
            gf16_times(off, v[15:12]) ^ gf16_times(diag, v[11:8]),
            gf16_times(diag, v[7:4]) ^ gf16_times(off, v[3:0]),
            gf16_times(off, v[7:4]) ^ gf16_times(diag, v[3:0])};
  endfunction

  function automatic key_byte_t rot_subst(key_byte_t w);
    return {ENC_SUBST[w[3:0]], ENC_SUBST[w[7:4]]};
  endfunction

  function automatic key_schedule_t round_keys(block_t key);
    key_byte_t     w2;
    key_byte_t     w3;
    key_byte_t     w4;
    key_schedule_t ks;
    w2 = key[15:8] ^ ROUND_CONST_1 ^ rot_subst(key[7:0]);
    w3 = w2 ^ key[7:0];
    w4 = w2 ^ ROUND_CONST_2 ^ rot_subst(w3);
    ks.k0 = key;
    ks.k1 = {w2, w3};
    ks.k2 = {w4, w4 ^ w3};
    return ks;
  endfunction

  function automatic block_t cipher_block(cipher_op_e op, block_t blk, block_t key);
    key_schedule_t ks;
    block_t        t;
    ks = round_keys(key);
    if (op == OP_ENCRYPT) begin
      t = subst_swap(blk ^ ks.k0, OP_ENCRYPT);
      t = column_mix(t, ENC_DIAG, ENC_OFF) ^ ks.k1;
      t = subst_swap(t, OP_ENCRYPT) ^ ks.k2;
    end else begin
      t = subst_swap(blk ^ ks.k2, OP_DECRYPT) ^ ks.k1;
      t = column_mix(t, DEC_DIAG, DEC_OFF);
      t = subst_swap(t, OP_DECRYPT) ^ ks.k0;
    end
    return t;
  endfunction

  initial begin
    mismatch_count = 0;
    pending_count  = 0;
    key_copy       = '0;
  end

  always @(posedge clk) begin
    block_t want;
    if (!rst_n) begin
      key_copy = '0;
      expected_blocks.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_blocks.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("[%0t] unexpected result transaction: result_block=%h",
                     $realtime, out_result_block);
          end
        end else begin
          want = expected_blocks.pop_front();
          if (out_result_block !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("[%0t] result_block mismatch: expected %h, actual %h",
                       $realtime, want, out_result_block);
            end
          end
        end
      end
      if (in_valid && !in_stall) begin
        expected_blocks.push_back(cipher_block(cipher_op_e'(in_operation), in_data_block,
                                               key_copy));
      end
      if (cfg_wr_en) begin
        key_copy = cfg_wr_data;
      end
    end
    pending_count = expected_blocks.size();
  end

endmodule

>>> tb/sv/tb_simplified_aes_cipher.sv
module tb_simplified_aes_cipher;
  timeunit 1ns;
  timeprecision 1ps;
  import saes_tb_pkg::*;

  localparam int PHASES         = 8;
  localparam int ITEMS_PER_PHASE = 225;
  localparam int HOLD_CYCLES    = 200;

  logic                         clk;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_stall;
  logic                         in_operation;
  logic [saes_pkg::BLOCK_W-1:0] in_data_block;
  logic                         out_valid;
  logic                         out_stall;
  logic [saes_pkg::BLOCK_W-1:0] out_result_block;
  logic                         cfg_wr_en;
  logic [saes_pkg::BLOCK_W-1:0] cfg_wr_data;
  int                           mismatch_count;
  int                           pending_count;

  bit idle_on       = 1'b1;
  bit hold_off_req  = 1'b0;
  bit hold_off_done = 1'b0;

  simplified_aes_cipher uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_operation     (in_operation),
    .in_data_block    (in_data_block),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_block (out_result_block),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data)
  );

  saes_cipher_checker chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_operation     (in_operation),
    .in_data_block    (in_data_block),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_block (out_result_block),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .mismatch_count   (mismatch_count),
    .pending_count    (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // offers one block, with an optional idle burst ahead of it
  task automatic send_block(input cipher_op_e op, input logic [15:0] blk);
    int gap;
    if (idle_on && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 13);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_operation  <= op;
    in_data_block <= blk;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 2) @(posedge clk);
  endtask

  task automatic write_key(input logic [15:0] key);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= key;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // result side: random stall bursts, plus one long hold-off on request
  initial begin : result_sink
    int burst;
    out_stall = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_off_req && !hold_off_done) begin
        hold_off_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 13);
        out_stall <= 1'b1;
        repeat (burst) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    logic [15:0] blk;
    logic [15:0] key;
    in_valid      = 1'b0;
    in_operation  = OP_ENCRYPT;
    in_data_block = '0;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    rst_n         = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset key
    send_block(OP_ENCRYPT, 16'h0000);
    send_block(OP_ENCRYPT, 16'hFFFF);
    send_block(OP_DECRYPT, 16'h0000);
    send_block(OP_DECRYPT, 16'hFFFF);
    send_block(OP_ENCRYPT, 16'h8000);
    send_block(OP_DECRYPT, 16'h0001);
    send_block(OP_ENCRYPT, 16'hAAAA);
    send_block(OP_DECRYPT, 16'h5555);
    // textbook vector
    write_key(16'hA73B);
    send_block(OP_ENCRYPT, 16'h6F6B);
    send_block(OP_DECRYPT, 16'h0738);
    send_block(OP_ENCRYPT, 16'h0000);
    send_block(OP_DECRYPT, 16'hFFFF);
    write_key(16'hFFFF);
    send_block(OP_ENCRYPT, 16'h0000);
    send_block(OP_ENCRYPT, 16'hFFFF);
    send_block(OP_DECRYPT, 16'h0000);
    send_block(OP_DECRYPT, 16'hFFFF);
    send_block(OP_ENCRYPT, 16'h1248);
    send_block(OP_DECRYPT, 16'h8421);

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       key = 16'h0000;
        1:       key = 16'hFFFF;
        2:       key = 16'h8001;
        3:       key = 16'h7FFE;
        default: key = 16'($urandom);
      endcase
      write_key(key);
      idle_on = (ph != 3) && (ph != PHASES - 1);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (ph == 1 && i == 20) begin
          hold_off_req = 1'b1;
        end
        case ($urandom_range(0, 9))
          0:       blk = 16'h0000;
          1:       blk = 16'hFFFF;
          2:       blk = 16'h0001 << $urandom_range(0, 15);
          default: blk = 16'($urandom);
        endcase
        send_block(cipher_op_e'($urandom_range(0, 1)), blk);
      end
    end

    drain();
    repeat (PIPE_LATENCY + 4) @(posedge clk);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
